@@ rtl/core/timed_transmit_slot_scheduler_core_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef TIMED_TRANSMIT_SLOT_SCHEDULER_CORE_MACROS_SVH
`define TIMED_TRANSMIT_SLOT_SCHEDULER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/tts_pkg.sv @@
package tts_pkg;

    localparam logic [31:0] LEAD_RESET = 32'd3000000;
    localparam logic [31:0] NO_TIME    = 32'hFFFFFFFF;

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ENQ  = 2'd1;
    localparam logic [1:0] EV_FULL = 2'd2;
    localparam logic [1:0] EV_FIRE = 2'd3;

    localparam logic [1:0] ACT_TX    = 2'd0;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
        logic        zero;
    } t_alu_res;

endpackage

@@ rtl/core/tts_alu.sv @@
module tts_alu
    import tts_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_res o_res
);

    logic [32:0] full;

    // One 33-bit subtractor serves the tick check, the ordering compare, the delay and the lead check.
    assign full         = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_res.diff   = full[31:0];
    assign o_res.borrow = full[32];
    assign o_res.zero   = (full[31:0] == 32'd0);

endmodule

@@ rtl/core/tts_slot_mem.sv @@
module tts_slot_mem
    import tts_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int WIDTH = 57
)
(
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

@@ rtl/core/timed_transmit_slot_scheduler_core.sv @@
// Enqueue: the input is registered, all slots are scanned for the earliest pending start, and
// that slot is checked against now and the max lead and then armed; each slot discarded there
// starts a new scan, and a scan that finds nothing pending skips the check. A firing tick frees
// its slot and rescans; a tick that does not fire, or finds nothing armed, goes to the result.
// One item at a time; the next item is taken while a finished result waits at the output.
// Synchronous active-low reset frees all slots, disarms, and sets max lead to 3000000.
`include "timed_transmit_slot_scheduler_core_macros.svh"

module timed_transmit_slot_scheduler_core
    import tts_pkg::*;
#(
    parameter int SLOTS   = 8,
    parameter int MAX_LEN = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_us[31:0], req_action[33:32], start_us[65:34], req_length[73:66],
    // payload_tag[89:74], zero fill[95:90]
    input  logic [95:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // slot_index[2:0], fired_action[4:3], fired_length[11:5], fired_tag[27:12],
    // discarded[31:28]
    output logic [31:0] m_axis_tdata,
    // event_res[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_wdata
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = $clog2(SLOTS + 1);
    localparam int EW = 32 + 2 + LW + 16;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_TICK, S_SCAN_INIT, S_SCAN, S_CHECK, S_LEAD, S_DONE
    } t_state;

    t_state r_state;

    logic [31:0]    r_max_lead;
    logic [SLOTS-1:0] r_occ;
    logic           r_armed_valid;
    logic [IW-1:0]  r_armed_slot;
    logic [31:0]    r_armed_start;
    logic [31:0]    r_now;
    logic [1:0]     r_ev;
    logic [IW-1:0]  r_sidx;
    logic [1:0]     r_fa;
    logic [LW-1:0]  r_fl;
    logic [15:0]    r_ft;
    logic [DW-1:0]  r_drop;
    logic           r_best_vld;
    logic [31:0]    r_best_start;
    logic [IW-1:0]  r_best_idx;
    logic [IW-1:0]  r_rd_idx;
    logic           r_issue_done;
    logic           r_cmp_vld;
    logic [IW-1:0]  r_cmp_idx;
    logic [31:0]    r_diff;
    logic           r_diff_zero;
    logic           r_out_valid;
    logic [1:0]     r_out_user;
    logic [31:0]    r_out_data;

    logic           in_op;
    logic [31:0]    in_now;
    logic [1:0]     in_act;
    logic [31:0]    in_start;
    logic [7:0]     in_len;
    logic [15:0]    in_tag;
    logic           s_acc;

    logic           free_found;
    logic [IW-1:0]  free_idx;
    logic           wr_en;
    logic [EW-1:0]  wr_data;
    logic [1:0]     act_st;
    logic [LW-1:0]  len_st;
    logic [IW-1:0]  rd_addr;
    logic [EW-1:0]  rd_data;
    logic [31:0]    rd_start;
    logic [1:0]     rd_act;
    logic [LW-1:0]  rd_len;
    logic [15:0]    rd_tag;
    logic [3:0]     drop_sat;

    t_alu_req       alu_req;
    t_alu_res       alu_res;

    assign in_now   = s_axis_tdata[31:0];
    assign in_act   = s_axis_tdata[33:32];
    assign in_start = s_axis_tdata[65:34];
    assign in_len   = s_axis_tdata[73:66];
    assign in_tag   = s_axis_tdata[89:74];
    assign in_op    = s_axis_tuser[0];

    // Nothing is taken while reset is held.
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

    // First free slot: lowest index whose valid bit is clear.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_occ[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign act_st  = (in_act == ACT_UNDEF) ? ACT_TX : in_act;
    assign len_st  = ((in_len >= 8'd1) && (in_len <= 8'(MAX_LEN))) ? LW'(in_len) : '0;
    assign wr_en   = s_acc && (in_op == OP_ENQ) && free_found && (in_start != 32'd0);
    assign wr_data = {in_tag, len_st, act_st, in_start};

    assign rd_addr  = (r_state == S_IDLE) ? r_armed_slot : r_rd_idx;
    assign rd_start = rd_data[31:0];
    assign rd_act   = rd_data[33:32];
    assign rd_len   = rd_data[34 +: LW];
    assign rd_tag   = rd_data[34 + LW +: 16];

    assign drop_sat = (32'(r_drop) > 32'd15) ? 4'd15 : 4'(r_drop);

    tts_slot_mem #(
        .DEPTH(SLOTS),
        .WIDTH(EW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(free_idx),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Operand selection for the shared subtractor.
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_TICK: begin
                alu_req.a = r_now;
                alu_req.b = r_armed_start;
            end
            S_SCAN: begin
                alu_req.a = r_best_start;
                alu_req.b = rd_start;
            end
            S_CHECK: begin
                alu_req.a = r_best_start;
                alu_req.b = r_now;
            end
            S_LEAD: begin
                alu_req.a = r_max_lead;
                alu_req.b = r_diff;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    tts_alu u_alu (
        .i_req(alu_req),
        .o_res(alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_max_lead    <= LEAD_RESET;
            r_occ         <= '0;
            r_armed_valid <= 1'b0;
            r_armed_slot  <= '0;
            r_armed_start <= '0;
            r_out_valid   <= 1'b0;
            r_drop        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max_lead <= i_cfg_wdata;
            end
            // In S_DONE the output register is reloaded below instead.
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_occ[free_idx] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_now  <= in_now;
                        r_fa   <= '0;
                        r_fl   <= '0;
                        r_ft   <= '0;
                        r_drop <= '0;
                        if (in_op == OP_ENQ) begin
                            if (!free_found) begin
                                r_ev   <= EV_FULL;
                                r_sidx <= '0;
                            end else if (in_start != 32'd0) begin
                                r_ev   <= EV_ENQ;
                                r_sidx <= free_idx;
                            end else begin
                                r_ev   <= EV_NONE;
                                r_sidx <= '0;
                            end
                            r_state <= S_SCAN_INIT;
                        end else begin
                            r_ev   <= EV_NONE;
                            r_sidx <= '0;
                            if (r_armed_valid) begin
                                r_state <= S_TICK;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_TICK: begin
                    // Fire once the time is reached: now - start is not negative.
                    if (!alu_res.diff[31]) begin
                        r_ev                <= EV_FIRE;
                        r_sidx              <= r_armed_slot;
                        r_fa                <= rd_act;
                        r_fl                <= rd_len;
                        r_ft                <= rd_tag;
                        r_occ[r_armed_slot] <= 1'b0;
                        r_armed_valid       <= 1'b0;
                        r_state             <= S_SCAN_INIT;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN_INIT: begin
                    r_armed_valid <= 1'b0;
                    r_best_vld    <= 1'b0;
                    r_best_start  <= NO_TIME;
                    r_best_idx    <= '0;
                    r_rd_idx      <= '0;
                    r_issue_done  <= 1'b0;
                    r_cmp_vld     <= 1'b0;
                    r_state       <= S_SCAN;
                end
                S_SCAN: begin
                    // Reads are issued one slot per cycle; each is compared in the cycle after, from the memory output.
                    r_cmp_vld <= !r_issue_done;
                    r_cmp_idx <= r_rd_idx;
                    if (!r_issue_done) begin
                        if (r_rd_idx == LAST) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    if (r_cmp_vld && r_occ[r_cmp_idx] && !alu_res.borrow) begin
                        r_best_vld   <= 1'b1;
                        r_best_start <= rd_start;
                        r_best_idx   <= r_cmp_idx;
                    end
                    if (r_cmp_vld && (r_cmp_idx == LAST)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!r_best_vld) begin
                        r_state <= S_DONE;
                    end else begin
                        r_diff      <= alu_res.diff;
                        r_diff_zero <= alu_res.zero;
                        r_state     <= S_LEAD;
                    end
                end
                S_LEAD: begin
                    // A delay of zero or less, or beyond the lead limit, drops the slot.
                    if (r_diff_zero || r_diff[31] || alu_res.borrow) begin
                        r_occ[r_best_idx] <= 1'b0;
                        r_drop            <= r_drop + 1'b1;
                        r_state           <= S_SCAN_INIT;
                    end else begin
                        r_armed_valid <= 1'b1;
                        r_armed_slot  <= r_best_idx;
                        r_armed_start <= r_best_start;
                        r_state       <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_ev;
                        r_out_data  <= {drop_sat, r_ft, 7'(r_fl), r_fa, 3'(r_sidx)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TTS_ASSERT_IMPL(a_armed_occupied, r_armed_valid, r_occ[r_armed_slot],
        "armed slot is not occupied")
    `TTS_ASSERT_IMPL(a_fired_freed, (r_state == S_DONE) && (r_ev == EV_FIRE), !r_occ[r_sidx],
        "fired slot still occupied")
    `TTS_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_axis_tready,
        "input taken again right after a transfer")

endmodule
